FILE: hdl/tigp_pkg.sv
package tigp_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 4096;

   localparam int RADIX_BITS  = 6;
   localparam int COLS_BITS   = 7;
   localparam int ROWS_BITS   = 13;
   localparam int ROW_BITS    = 12;
   localparam int COL_BITS    = 6;
   localparam int BYTE_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIX   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLUMNS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS    = 2'd2;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET   = 6'd10;
   localparam logic [COLS_BITS-1:0]  COLUMNS_RESET = 7'd8;
   localparam logic [ROWS_BITS-1:0]  ROWS_RESET    = 13'd8;

   localparam logic [BYTE_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_HASH    = 8'h23;
   localparam logic [BYTE_BITS-1:0] CH_DOT     = 8'h2E;
   localparam logic [BYTE_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [BYTE_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_BITS-1:0] LETTER_BASE = 8'd10;

   localparam logic [STATUS_BITS-1:0] ST_RUNNING  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_COMPLETE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD_DIGIT = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NEED_NL  = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_CELL,
      MODE_DIGITS,
      MODE_TRAIL,
      MODE_COMMENT,
      MODE_DONE,
      MODE_ERR_DIGIT,
      MODE_ERR_NL
   } mode_type;

   typedef struct packed {
      logic                  ok;
      logic [RADIX_BITS-1:0] value;
   } digit_type;

   function automatic logic is_blank(input logic [BYTE_BITS-1:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic digit_type digit_of(input logic [BYTE_BITS-1:0] b);
      digit_type d;
      logic [BYTE_BITS-1:0] t;
      d = '0;
      t = '0;
      if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
         t = b - CH_ZERO;
         d.ok = 1'b1;
      end else if ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
         t = b - CH_UPPER_A + LETTER_BASE;
         d.ok = 1'b1;
      end
      d.value = t[RADIX_BITS-1:0];
      return d;
   endfunction

   function automatic logic [STATUS_BITS-1:0] status_of(input mode_type m);
      logic [STATUS_BITS-1:0] s;
      case (m)
         MODE_DONE:      s = ST_COMPLETE;
         MODE_ERR_DIGIT: s = ST_BAD_DIGIT;
         MODE_ERR_NL:    s = ST_NEED_NL;
         default:        s = ST_RUNNING;
      endcase
      return s;
   endfunction

endpackage

FILE: hdl/tigp_if.sv
interface tigp_req_if;
   logic                            valid;
   logic                            ready;
   logic [tigp_pkg::BYTE_BITS-1:0]  text_byte;
   logic                            begin_map;

   modport source  (output valid, output text_byte, output begin_map, input ready);
   modport sink    (input valid, input text_byte, input begin_map, output ready);
   modport monitor (input valid, input text_byte, input begin_map, input ready);
endinterface

interface tigp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tigp_pkg::VALUE_BITS-1:0] cell_value;
   logic                                  value_valid;
   logic [tigp_pkg::ROW_BITS-1:0]         row_index;
   logic [tigp_pkg::COL_BITS-1:0]         col_index;
   logic [tigp_pkg::STATUS_BITS-1:0]      status;
   logic                                  last_of_run;

   modport source  (output valid, output cell_value, output value_valid, output row_index,
                    output col_index, output status, output last_of_run, input ready);
   modport sink    (input valid, input cell_value, input value_valid, input row_index,
                    input col_index, input status, input last_of_run, output ready);
   modport monitor (input valid, input cell_value, input value_valid, input row_index,
                    input col_index, input status, input last_of_run, input ready);
endinterface

FILE: hdl/text_integer_grid_parser.sv
// channel  | direction | words carried
// ---------+-----------+----------------------------------------------------------
// req_ch   | in        | text_byte, begin_map
// rsp_ch   | out       | cell_value, value_valid, row_index, col_index, status, last
// csr_*    | in        | radix (0), columns (1), rows (2); write only
//
// A byte is registered on entry and worked out once the output register is free; its first
// result word is then registered. One word leaves per cycle while rsp ready holds: a byte
// gives one word, or one per cell when a newline closes and pads a short row (up to the column
// count); input stalls until the last pad is registered. The digit multiply-add sets the path.
// Reset is synchronous and active high: parser idle, config back to radix 10, 8 by 8.
// A stalled result holds in the output register; one more byte waits in the input register.
module text_integer_grid_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   tigp_req_if.sink                             req_ch,
   tigp_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [tigp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tigp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [tigp_pkg::RADIX_BITS-1:0] radix_ff, radix_in;
   logic [tigp_pkg::COLS_BITS-1:0]  columns_ff, columns_in;
   logic [tigp_pkg::ROWS_BITS-1:0]  rows_ff, rows_in;

   tigp_pkg::mode_type              mode_ff, mode_in;
   logic [tigp_pkg::VALUE_BITS-1:0] acc_ff, acc_in;
   logic [tigp_pkg::ROW_BITS-1:0]   row_ff, row_in;
   logic [tigp_pkg::COLS_BITS-1:0]  col_ff, col_in;
   logic                            pad_ff, pad_in;
   logic [tigp_pkg::STATUS_BITS-1:0] st_ff, st_in;

   logic                            ex_valid_ff, ex_valid_in;
   logic [tigp_pkg::BYTE_BITS-1:0]  ex_byte_ff, ex_byte_in;
   logic                            ex_begin_ff, ex_begin_in;

   logic                            out_valid_ff, out_valid_in;
   logic [tigp_pkg::VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                            out_vv_ff, out_vv_in;
   logic [tigp_pkg::ROW_BITS-1:0]   out_row_ff, out_row_in;
   logic [tigp_pkg::COL_BITS-1:0]   out_col_ff, out_col_in;
   logic [tigp_pkg::STATUS_BITS-1:0] out_st_ff, out_st_in;
   logic                            out_last_ff, out_last_in;

   logic                            out_free;
   logic                            step;
   logic                            ex_done;
   logic                            accept;
   logic [tigp_pkg::COLS_BITS-1:0]  eff_cols;
   logic [tigp_pkg::ROWS_BITS-1:0]  eff_rows;

   always_comb begin
      unique case (csr_index)
         tigp_pkg::CSR_RADIX,
         tigp_pkg::CSR_COLUMNS,
         tigp_pkg::CSR_ROWS: ;
         default: ;
      endcase
      radix_in   = radix_ff;
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            tigp_pkg::CSR_RADIX:   radix_in   = csr_wdata[tigp_pkg::RADIX_BITS-1:0];
            tigp_pkg::CSR_COLUMNS: columns_in = csr_wdata[tigp_pkg::COLS_BITS-1:0];
            tigp_pkg::CSR_ROWS:    rows_in    = csr_wdata[tigp_pkg::ROWS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (columns_ff == '0) begin
         eff_cols = tigp_pkg::COLS_BITS'(1);
      end else if (columns_ff > tigp_pkg::COLS_BITS'(tigp_pkg::MAX_COLUMNS)) begin
         eff_cols = tigp_pkg::COLS_BITS'(tigp_pkg::MAX_COLUMNS);
      end else begin
         eff_cols = columns_ff;
      end
      if (rows_ff == '0) begin
         eff_rows = tigp_pkg::ROWS_BITS'(1);
      end else if (rows_ff > tigp_pkg::ROWS_BITS'(tigp_pkg::MAX_ROWS)) begin
         eff_rows = tigp_pkg::ROWS_BITS'(tigp_pkg::MAX_ROWS);
      end else begin
         eff_rows = rows_ff;
      end
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign step     = ex_valid_ff && out_free;
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !ex_valid_ff || ex_done;

   always_comb begin
      tigp_pkg::mode_type              m0, m1, m_fin;
      logic [tigp_pkg::VALUE_BITS-1:0] a0, a1, v, prod;
      logic [tigp_pkg::ROW_BITS-1:0]   r0;
      logic [tigp_pkg::COLS_BITS-1:0]  c0, c_after, c_next;
      logic                            emit_v, nl_pad, rd_direct, rd, pad_first, has_res;
      logic                            more_pads, done_cond;
      logic                            blank;
      tigp_pkg::digit_type             d;
      logic [tigp_pkg::STATUS_BITS-1:0] st;

      m0 = mode_ff; m1 = mode_ff; m_fin = mode_ff;
      a0 = acc_ff; a1 = acc_ff; v = '0; prod = '0;
      r0 = row_ff; c0 = col_ff; c_after = col_ff; c_next = col_ff;
      emit_v = 1'b0; nl_pad = 1'b0; rd_direct = 1'b0; rd = 1'b0;
      pad_first = 1'b0; has_res = 1'b0; more_pads = 1'b0; done_cond = 1'b0;
      blank = tigp_pkg::is_blank(ex_byte_ff);
      d = tigp_pkg::digit_of(ex_byte_ff);
      st = st_ff;

      mode_in = mode_ff; acc_in = acc_ff; row_in = row_ff; col_in = col_ff;
      pad_in = pad_ff; st_in = st_ff; ex_done = 1'b0;
      out_value_in = out_value_ff; out_vv_in = out_vv_ff; out_row_in = out_row_ff;
      out_col_in = out_col_ff; out_st_in = out_st_ff; out_last_in = out_last_ff;

      if (step && pad_ff) begin
         c_next       = col_ff + tigp_pkg::COLS_BITS'(1);
         out_value_in = '0;
         out_vv_in    = 1'b1;
         out_row_in   = row_ff;
         out_col_in   = col_ff[tigp_pkg::COL_BITS-1:0];
         out_st_in    = st_ff;
         col_in       = c_next;
         if (c_next >= eff_cols) begin
            out_last_in = 1'b1;
            ex_done     = 1'b1;
            pad_in      = 1'b0;
            if (mode_ff != tigp_pkg::MODE_DONE) begin
               row_in = row_ff + tigp_pkg::ROW_BITS'(1);
               col_in = '0;
            end
         end else begin
            out_last_in = 1'b0;
         end
      end else if (step) begin
         if (ex_begin_ff) begin
            m0 = tigp_pkg::MODE_CELL;
            a0 = '0;
            r0 = '0;
            c0 = '0;
         end
         m1 = m0;
         a1 = a0;
         prod = a0 * tigp_pkg::VALUE_BITS'(radix_ff);
         unique case (m0)
            tigp_pkg::MODE_CELL: begin
               if (c0 == '0 && blank) begin
               end else if (c0 == '0 && ex_byte_ff == tigp_pkg::CH_HASH) begin
                  m1 = tigp_pkg::MODE_COMMENT;
               end else if (ex_byte_ff == tigp_pkg::CH_NEWLINE) begin
                  nl_pad = 1'b1;
               end else if (blank) begin
               end else if (ex_byte_ff == tigp_pkg::CH_DOT) begin
                  emit_v = 1'b1;
                  v      = '1;
                  m1 = (c0 + tigp_pkg::COLS_BITS'(1) >= eff_cols) ?
                       tigp_pkg::MODE_TRAIL : tigp_pkg::MODE_CELL;
               end else if (d.ok) begin
                  a1 = tigp_pkg::VALUE_BITS'(d.value);
                  m1 = tigp_pkg::MODE_DIGITS;
               end else begin
                  m1 = tigp_pkg::MODE_ERR_DIGIT;
               end
            end
            tigp_pkg::MODE_DIGITS: begin
               if (blank) begin
                  emit_v = 1'b1;
                  v      = a0;
                  a1     = '0;
                  if (ex_byte_ff == tigp_pkg::CH_NEWLINE) begin
                     nl_pad = 1'b1;
                  end else begin
                     m1 = (c0 + tigp_pkg::COLS_BITS'(1) >= eff_cols) ?
                          tigp_pkg::MODE_TRAIL : tigp_pkg::MODE_CELL;
                  end
               end else if (d.ok) begin
                  a1 = prod + tigp_pkg::VALUE_BITS'(d.value);
               end else begin
                  m1 = tigp_pkg::MODE_ERR_DIGIT;
               end
            end
            tigp_pkg::MODE_TRAIL: begin
               if (ex_byte_ff == tigp_pkg::CH_NEWLINE) begin
                  rd_direct = 1'b1;
               end else if (blank) begin
               end else if (ex_byte_ff == tigp_pkg::CH_HASH) begin
                  m1 = tigp_pkg::MODE_COMMENT;
               end else begin
                  m1 = tigp_pkg::MODE_ERR_NL;
               end
            end
            tigp_pkg::MODE_COMMENT: begin
               if (ex_byte_ff == tigp_pkg::CH_NEWLINE) begin
                  rd_direct = 1'b1;
               end else if (ex_byte_ff == tigp_pkg::CH_NUL) begin
                  m1 = tigp_pkg::MODE_ERR_NL;
               end
            end
            default: ;
         endcase

         pad_first = nl_pad && !emit_v && (c0 < eff_cols);
         has_res   = emit_v || pad_first;
         c_after   = c0 + tigp_pkg::COLS_BITS'(has_res);
         more_pads = nl_pad && (c_after < eff_cols);
         rd        = rd_direct || nl_pad;
         done_cond = ({1'b0, r0} + tigp_pkg::ROWS_BITS'(1)) >= eff_rows;
         if (rd) begin
            m_fin = done_cond ? tigp_pkg::MODE_DONE : tigp_pkg::MODE_CELL;
         end else begin
            m_fin = m1;
         end
         st = tigp_pkg::status_of(m_fin);

         out_value_in = emit_v ? v : '0;
         out_vv_in    = has_res;
         out_row_in   = has_res ? r0 : '0;
         out_col_in   = has_res ? c0[tigp_pkg::COL_BITS-1:0] : '0;
         out_st_in    = st;
         out_last_in  = !more_pads;

         mode_in = m_fin;
         acc_in  = a1;
         if (more_pads) begin
            row_in = r0;
            col_in = c_after;
            pad_in = 1'b1;
            st_in  = st;
         end else if (rd && !done_cond) begin
            row_in  = r0 + tigp_pkg::ROW_BITS'(1);
            col_in  = '0;
            ex_done = 1'b1;
         end else begin
            row_in  = r0;
            col_in  = c_after;
            ex_done = 1'b1;
         end
      end
   end

   always_comb begin
      ex_byte_in  = ex_byte_ff;
      ex_begin_in = ex_begin_ff;
      if (accept) begin
         ex_valid_in = 1'b1;
         ex_byte_in  = req_ch.text_byte;
         ex_begin_in = req_ch.begin_map;
      end else if (ex_done) begin
         ex_valid_in = 1'b0;
      end else begin
         ex_valid_in = ex_valid_ff;
      end
      out_valid_in = out_free ? ex_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= tigp_pkg::RADIX_RESET;
         columns_ff   <= tigp_pkg::COLUMNS_RESET;
         rows_ff      <= tigp_pkg::ROWS_RESET;
         mode_ff      <= tigp_pkg::MODE_IDLE;
         acc_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         pad_ff       <= 1'b0;
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pad_ff       <= pad_in;
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff        <= st_in;
      ex_byte_ff   <= ex_byte_in;
      ex_begin_ff  <= ex_begin_in;
      out_value_ff <= out_value_in;
      out_vv_ff    <= out_vv_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_st_ff    <= out_st_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.cell_value  = out_value_ff;
   assign rsp_ch.value_valid = out_vv_ff;
   assign rsp_ch.row_index   = out_row_ff;
   assign rsp_ch.col_index   = out_col_ff;
   assign rsp_ch.status      = out_st_ff;
   assign rsp_ch.last_of_run = out_last_ff;

endmodule

FILE: hdl/tigp_checker.sv
module tigp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [tigp_pkg::VALUE_BITS-1:0]       rsp_cell_value,
   input logic                                  rsp_value_valid,
   input logic [tigp_pkg::ROW_BITS-1:0]         rsp_row_index,
   input logic [tigp_pkg::COL_BITS-1:0]         rsp_col_index,
   input logic [tigp_pkg::STATUS_BITS-1:0]      rsp_status,
   input logic                                  rsp_last_of_run
);

   // hold a stalled word's value and last flag unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_cell_value) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |->
         rsp_cell_value == '0 && rsp_row_index == '0 && rsp_col_index == '0
         && rsp_last_of_run)
      else $error("empty result word carries payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         !rsp_valid || rsp_value_valid)
      else $error("padding run broken by an empty word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status[1] |-> !rsp_value_valid && rsp_last_of_run)
      else $error("error status on a value word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         !req_ready || !rsp_valid || rsp_ready)
      else $error("input taken while a stalled run is pending");

endmodule

bind text_integer_grid_parser tigp_checker u_tigp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_cell_value  (rsp_ch.cell_value),
   .rsp_value_valid (rsp_ch.value_valid),
   .rsp_row_index   (rsp_ch.row_index),
   .rsp_col_index   (rsp_ch.col_index),
   .rsp_status      (rsp_ch.status),
   .rsp_last_of_run (rsp_ch.last_of_run)
);
